FILE: hw/rtl/lrfb_pkg.sv
// ----------------------------------------------------------------------------
// lrfb_pkg: shared types and codes of the line rasterizer framebuffer
// Command codes, the decoded operation that travels from the front end to
// the back end, and fixed widths that follow from the 8-bit coordinates.
// ----------------------------------------------------------------------------
package lrfb_pkg;

    localparam logic [1:0] CMD_CLEAR = 2'd0;
    localparam logic [1:0] CMD_LINE  = 2'd1;
    localparam logic [1:0] CMD_READ  = 2'd2;

    // page (5 bits) times width (8 bits) plus column fits in 13 bits
    localparam int IDX_W  = 13;
    localparam int RADR_W = 10;

    typedef struct packed {
        logic [1:0]        cmd;
        logic              steep;
        logic              step_down;
        logic              ink;
        logic [7:0]        major0;
        logic [7:0]        minor0;
        logic [7:0]        dx;
        logic [7:0]        dy;
        logic [RADR_W-1:0] read_address;
    } line_op_t;

endpackage

FILE: hw/rtl/lrfb_front.sv
// ----------------------------------------------------------------------------
// lrfb_front: command intake and line setup
// Registers one incoming transaction, orders the endpoints, works out the
// steep flag, deltas and minor step direction, and pushes the operation.
// ----------------------------------------------------------------------------
module lrfb_front (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                init_busy,
    input  logic                s_tvalid,
    output logic                s_tready,
    // x_start[7:0], y_start[15:8], x_end[23:16], y_end[31:24], ink[32],
    // read_address[42:33], zero fill [47:43]
    input  logic [47:0]         s_tdata,
    // command[1:0]
    input  logic [1:0]          s_tuser,
    output logic                q_push,
    input  logic                q_ready,
    output lrfb_pkg::line_op_t  q_data
);

    logic                        in_valid_reg, in_valid_next;
    logic [1:0]                  cmd_reg;
    logic [7:0]                  x0_reg, y0_reg, x1_reg, y1_reg;
    logic                        ink_reg;
    logic [lrfb_pkg::RADR_W-1:0] radr_reg;

    logic [7:0] adx, ady;
    logic       steep;
    logic [7:0] a0, b0, a1, b1;
    logic       accept;

    assign q_push   = in_valid_reg && q_ready;
    assign s_tready = !init_busy && (!in_valid_reg || q_ready);
    assign accept   = s_tvalid && s_tready;

    always_comb begin
        in_valid_next = in_valid_reg;
        if (accept) begin
            in_valid_next = 1'b1;
        end else if (q_push) begin
            in_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else begin
            in_valid_reg <= in_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            cmd_reg  <= s_tuser;
            x0_reg   <= s_tdata[7:0];
            y0_reg   <= s_tdata[15:8];
            x1_reg   <= s_tdata[23:16];
            y1_reg   <= s_tdata[31:24];
            ink_reg  <= s_tdata[32];
            radr_reg <= s_tdata[42:33];
        end
    end

    always_comb begin
        adx   = (x1_reg >= x0_reg) ? (x1_reg - x0_reg) : (x0_reg - x1_reg);
        ady   = (y1_reg >= y0_reg) ? (y1_reg - y0_reg) : (y0_reg - y1_reg);
        steep = ady > adx;
        // a is the major axis, b the minor axis
        a0 = steep ? y0_reg : x0_reg;
        b0 = steep ? x0_reg : y0_reg;
        a1 = steep ? y1_reg : x1_reg;
        b1 = steep ? x1_reg : y1_reg;

        q_data.cmd          = cmd_reg;
        q_data.steep        = steep;
        q_data.ink          = ink_reg;
        q_data.read_address = radr_reg;
        q_data.dx           = steep ? ady : adx;
        q_data.dy           = steep ? adx : ady;
        if (a0 > a1) begin
            q_data.major0    = a1;
            q_data.minor0    = b1;
            q_data.step_down = !(b1 < b0);
        end else begin
            q_data.major0    = a0;
            q_data.minor0    = b0;
            q_data.step_down = !(b0 < b1);
        end
    end

endmodule

FILE: hw/rtl/lrfb_queue.sv
// ----------------------------------------------------------------------------
// lrfb_queue: two-entry operation queue
// Decouples command setup from the pixel engine so either side can stall.
// ----------------------------------------------------------------------------
module lrfb_queue (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                push,
    output logic                ready,
    input  lrfb_pkg::line_op_t  wr_data,
    output logic                valid,
    input  logic                pop,
    output lrfb_pkg::line_op_t  rd_data
);

    lrfb_pkg::line_op_t entry_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;

    assign ready   = count_reg != 2'd2;
    assign valid   = count_reg != 2'd0;
    assign rd_data = entry_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop  ? !rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop) begin
            count_next = count_reg + 2'd1;
        end else if (pop && !push) begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

FILE: hw/rtl/lrfb_back.sv
// ----------------------------------------------------------------------------
// lrfb_back: framebuffer store and pixel engine
// Holds the paged store, walks Bresenham lines with a pipelined
// read-modify-write per pixel, sweeps clears, serves reads and drives the
// result register.
// ----------------------------------------------------------------------------
module lrfb_back #(
    parameter int SCREEN_WIDTH  = 96,
    parameter int SCREEN_HEIGHT = 68,
    parameter int PAGE_COUNT    = 9
) (
    input  logic                aclk,
    input  logic                aresetn,
    output logic                init_busy,
    input  logic                q_valid,
    output logic                q_pop,
    input  lrfb_pkg::line_op_t  q_data,
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [7:0]          m_tdata
);

    localparam int STORE_DEPTH = SCREEN_WIDTH * PAGE_COUNT;
    localparam int AW = $clog2(STORE_DEPTH);
    localparam int CW = (AW > lrfb_pkg::RADR_W) ? AW : lrfb_pkg::RADR_W;

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_CLEAR  = 3'd1;
    localparam logic [2:0] S_LINE   = 3'd2;
    localparam logic [2:0] S_READ   = 3'd3;
    localparam logic [2:0] S_FINISH = 3'd4;

    logic [7:0] mem [STORE_DEPTH];
    logic [7:0] rd_data_reg;

    logic [2:0]        state_reg, state_next;
    logic              init_reg, init_next;
    logic [AW-1:0]     clr_addr_reg, clr_addr_next;
    logic [7:0]        major_reg, major_next;
    logic [7:0]        minor_reg, minor_next;
    logic signed [9:0] err_reg, err_next;
    logic [7:0]        remain_reg, remain_next;
    logic [7:0]        dx_reg, dx_next;
    logic [7:0]        dy_reg, dy_next;
    logic              steep_reg, steep_next;
    logic              step_down_reg, step_down_next;
    logic              ink_reg, ink_next;
    logic              read_ok_reg, read_ok_next;
    logic [7:0]        res_reg, res_next;

    // pixel write stage and the write of the cycle before it
    logic              pb_valid_reg, pb_valid_next;
    logic [AW-1:0]     pb_addr_reg, pb_addr_next;
    logic [2:0]        pb_bit_reg, pb_bit_next;
    logic              pb_ink_reg, pb_ink_next;
    logic              pw_valid_reg;
    logic [AW-1:0]     pw_addr_reg;
    logic [7:0]        pw_data_reg;

    logic              out_valid_reg, out_valid_next;
    logic [7:0]        out_data_reg, out_data_next;

    logic              rd_en, wr_en;
    logic [AW-1:0]     rd_addr, wr_addr;
    logic [7:0]        wr_data;

    logic [7:0]                 col, row;
    logic [4:0]                 page;
    logic [lrfb_pkg::IDX_W-1:0] idx_wide;
    logic                       on_screen;
    logic signed [9:0]          err_tmp;
    logic [CW-1:0]              radr_wide;
    logic [7:0]                 pix_old, pix_mask;

    assign init_busy = init_reg;
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = out_data_reg;
    assign q_pop     = (state_reg == S_IDLE) && q_valid;

    // pixel address of the current walker position
    always_comb begin
        col       = steep_reg ? minor_reg : major_reg;
        row       = steep_reg ? major_reg : minor_reg;
        page      = row[7:3];
        idx_wide  = lrfb_pkg::IDX_W'(page) * lrfb_pkg::IDX_W'(SCREEN_WIDTH)
                  + lrfb_pkg::IDX_W'(col);
        on_screen = (col < 8'(SCREEN_WIDTH)) && (row < 8'(SCREEN_HEIGHT))
                 && (6'(page) < 6'(PAGE_COUNT));
        err_tmp   = err_reg - $signed({2'b00, dy_reg});
        radr_wide = CW'(q_data.read_address);
    end

    // modify stage: forward last cycle's write when it hit the same byte
    always_comb begin
        pix_old  = (pw_valid_reg && (pw_addr_reg == pb_addr_reg)) ? pw_data_reg
                                                                  : rd_data_reg;
        pix_mask = 8'd1 << pb_bit_reg;
        wr_en    = pb_valid_reg;
        wr_addr  = pb_addr_reg;
        wr_data  = pb_ink_reg ? (pix_old | pix_mask) : (pix_old & ~pix_mask);
        if (state_reg == S_CLEAR) begin
            wr_en   = 1'b1;
            wr_addr = clr_addr_reg;
            wr_data = 8'd0;
        end
    end

    always_comb begin
        state_next     = state_reg;
        init_next      = init_reg;
        clr_addr_next  = clr_addr_reg;
        major_next     = major_reg;
        minor_next     = minor_reg;
        err_next       = err_reg;
        remain_next    = remain_reg;
        dx_next        = dx_reg;
        dy_next        = dy_reg;
        steep_next     = steep_reg;
        step_down_next = step_down_reg;
        ink_next       = ink_reg;
        read_ok_next   = read_ok_reg;
        res_next       = res_reg;
        pb_valid_next  = 1'b0;
        pb_addr_next   = idx_wide[AW-1:0];
        pb_bit_next    = row[2:0];
        pb_ink_next    = ink_reg;
        out_valid_next = out_valid_reg && !m_tready;
        out_data_next  = out_data_reg;
        rd_en          = 1'b0;
        rd_addr        = idx_wide[AW-1:0];

        unique case (state_reg)
            S_IDLE: begin
                if (q_valid) begin
                    clr_addr_next  = '0;
                    major_next     = q_data.major0;
                    minor_next     = q_data.minor0;
                    err_next       = $signed({2'b00, q_data.dx >> 1});
                    remain_next    = q_data.dx;
                    dx_next        = q_data.dx;
                    dy_next        = q_data.dy;
                    steep_next     = q_data.steep;
                    step_down_next = q_data.step_down;
                    ink_next       = q_data.ink;
                    read_ok_next   = radr_wide < CW'(STORE_DEPTH);
                    res_next       = 8'd0;
                    unique case (q_data.cmd)
                        lrfb_pkg::CMD_CLEAR: state_next = S_CLEAR;
                        lrfb_pkg::CMD_LINE:  state_next = S_LINE;
                        lrfb_pkg::CMD_READ: begin
                            rd_en      = 1'b1;
                            rd_addr    = radr_wide[AW-1:0];
                            state_next = S_READ;
                        end
                        default: state_next = S_FINISH;
                    endcase
                end
            end
            S_CLEAR: begin
                clr_addr_next = clr_addr_reg + AW'(1);
                if (clr_addr_reg == AW'(STORE_DEPTH - 1)) begin
                    if (init_reg) begin
                        init_next  = 1'b0;
                        state_next = S_IDLE;
                    end else begin
                        state_next = S_FINISH;
                    end
                end
            end
            S_LINE: begin
                // issue the read for this pixel, then step the walker
                rd_en         = on_screen;
                pb_valid_next = on_screen;
                major_next    = major_reg + 8'd1;
                remain_next   = remain_reg - 8'd1;
                if (err_tmp < 0) begin
                    minor_next = step_down_reg ? (minor_reg - 8'd1) : (minor_reg + 8'd1);
                    err_next   = err_tmp + $signed({2'b00, dx_reg});
                end else begin
                    err_next   = err_tmp;
                end
                if (remain_reg == 8'd0) begin
                    state_next = S_FINISH;
                end
            end
            S_READ: begin
                res_next   = read_ok_reg ? rd_data_reg : 8'd0;
                state_next = S_FINISH;
            end
            S_FINISH: begin
                if (!out_valid_reg || m_tready) begin
                    out_valid_next = 1'b1;
                    out_data_next  = res_reg;
                    state_next     = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_CLEAR;
            init_reg      <= 1'b1;
            clr_addr_reg  <= '0;
            pb_valid_reg  <= 1'b0;
            pw_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            init_reg      <= init_next;
            clr_addr_reg  <= clr_addr_next;
            pb_valid_reg  <= pb_valid_next;
            pw_valid_reg  <= pb_valid_reg;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        major_reg     <= major_next;
        minor_reg     <= minor_next;
        err_reg       <= err_next;
        remain_reg    <= remain_next;
        dx_reg        <= dx_next;
        dy_reg        <= dy_next;
        steep_reg     <= steep_next;
        step_down_reg <= step_down_next;
        ink_reg       <= ink_next;
        read_ok_reg   <= read_ok_next;
        res_reg       <= res_next;
        pb_addr_reg   <= pb_addr_next;
        pb_bit_reg    <= pb_bit_next;
        pb_ink_reg    <= pb_ink_next;
        pw_addr_reg   <= pb_addr_reg;
        pw_data_reg   <= wr_data;
        out_data_reg  <= out_data_next;
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

endmodule

FILE: hw/rtl/line_rasterizer_framebuffer_top.sv
// Line draw: dx+1 pixels (one read-modify-write per cycle on the single
// store). Clear: all STORE_DEPTH bytes are zeroed in turn. Every command ends
// in S_FINISH, which registers its result byte onto m_tvalid and m_tdata.
// A result held back by m_tready stalls the engine, then the queue, then s_tready.
// Reset: synchronous, active low; afterwards a clearing pass zeroes all
// STORE_DEPTH bytes of the store while s_tready stays low.
// ----------------------------------------------------------------------------
// line_rasterizer_framebuffer_top: paged monochrome framebuffer with lines
// Front end decodes commands, a two-entry queue buffers them, and the back end
// draws Bresenham lines, clears and reads the byte store.
// ----------------------------------------------------------------------------
module line_rasterizer_framebuffer_top #(
    parameter int SCREEN_WIDTH  = 96,
    parameter int SCREEN_HEIGHT = 68,
    parameter int PAGE_COUNT    = 9
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // x_start[7:0], y_start[15:8], x_end[23:16], y_end[31:24], ink[32],
    // read_address[42:33], zero fill [47:43]
    input  logic [47:0] s_tdata,
    // command[1:0]
    input  logic [1:0]  s_tuser,
    output logic        m_tvalid,
    input  logic        m_tready,
    // read_data[7:0]
    output logic [7:0]  m_tdata
);

    logic               init_busy;
    logic               q_push, q_ready, q_valid, q_pop;
    lrfb_pkg::line_op_t q_wr_data, q_rd_data;

    lrfb_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .init_busy (init_busy),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .q_push    (q_push),
        .q_ready   (q_ready),
        .q_data    (q_wr_data)
    );

    lrfb_queue u_queue (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (q_push),
        .ready   (q_ready),
        .wr_data (q_wr_data),
        .valid   (q_valid),
        .pop     (q_pop),
        .rd_data (q_rd_data)
    );

    lrfb_back #(
        .SCREEN_WIDTH  (SCREEN_WIDTH),
        .SCREEN_HEIGHT (SCREEN_HEIGHT),
        .PAGE_COUNT    (PAGE_COUNT)
    ) u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .init_busy (init_busy),
        .q_valid   (q_valid),
        .q_pop     (q_pop),
        .q_data    (q_rd_data),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    // no transaction on either side while the store is being swept after reset
    a_init_quiet: assert property (@(posedge aclk) disable iff (!aresetn)
        init_busy |-> (!s_tready && !m_tvalid && !q_valid))
        else $error("transaction during post-reset clearing pass");

    a_pop_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        q_pop |-> q_valid)
        else $error("pixel engine took an operation from an empty queue");

    a_push_room: assert property (@(posedge aclk) disable iff (!aresetn)
        (q_push && !q_pop && !q_ready) |-> 1'b0)
        else $error("operation pushed into a full queue");

endmodule

FILE: dv/line_rasterizer_framebuffer_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// line_rasterizer_framebuffer_checker: scoreboard for the line rasterizer
// Watches both stream channels and keeps a shadow copy of the paged pixel
// store. Every accepted command updates the shadow copy and queues the byte
// the block has to return. Every accepted result is compared with the oldest
// queued byte.
// ----------------------------------------------------------------------------
module line_rasterizer_framebuffer_checker #(
    parameter int SCREEN_WIDTH  = 96,
    parameter int SCREEN_HEIGHT = 68,
    parameter int PAGE_COUNT    = 9
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    input  logic        s_tready,
    // x_start[7:0], y_start[15:8], x_end[23:16], y_end[31:24], ink[32],
    // read_address[42:33], zero fill [47:43]
    input  logic [47:0] s_tdata,
    // command[1:0]
    input  logic [1:0]  s_tuser,
    input  logic        m_tvalid,
    input  logic        m_tready,
    // read_data[7:0]
    input  logic [7:0]  m_tdata,
    output int          fail_count,
    output int          pending
);

    localparam int STORE_DEPTH    = SCREEN_WIDTH * PAGE_COUNT;

    logic [7:0] shadow_store [STORE_DEPTH];
    logic [7:0] read_data_queue [$];
    int         mismatches = 0;

    function automatic void paint_pixel(int col, int row, bit ink);
        int idx;
        if (col < 0 || col >= SCREEN_WIDTH || row < 0 || row >= SCREEN_HEIGHT)
            return;
        if (row / 8 >= PAGE_COUNT)
            return;
        idx = (row / 8) * SCREEN_WIDTH + col;
        if (idx >= STORE_DEPTH)
            return;
        shadow_store[idx][row % 8] = ink;
    endfunction

    function automatic void trace_line(int ax, int ay, int bx, int by, bit ink);
        bit steep;
        int tmp;
        int run;
        int rise;
        int err;
        int dir;
        int major_pos;
        int minor_pos;
        int n;
        steep = ((by > ay) ? by - ay : ay - by) > ((bx > ax) ? bx - ax : ax - bx);
        if (steep) begin
            tmp = ax; ax = ay; ay = tmp;
            tmp = bx; bx = by; by = tmp;
        end
        // walk the major axis upward
        if (ax > bx) begin
            tmp = ax; ax = bx; bx = tmp;
            tmp = ay; ay = by; by = tmp;
        end
        run       = bx - ax;
        rise      = (by > ay) ? by - ay : ay - by;
        err       = run / 2;
        dir       = (ay < by) ? 1 : -1;
        major_pos = ax;
        minor_pos = ay;
        for (n = 0; n <= run; n++) begin
            if (steep)
                paint_pixel(minor_pos, major_pos, ink);
            else
                paint_pixel(major_pos, minor_pos, ink);
            err -= rise;
            if (err < 0) begin
                minor_pos += dir;
                err       += run;
            end
            major_pos++;
        end
    endfunction

    function automatic logic [7:0] predict_read_data(logic [1:0] cmd, logic [47:0] data);
        logic [9:0] addr;
        logic [7:0] value;
        addr  = data[42:33];
        value = '0;
        case (cmd)
            lrfb_pkg::CMD_CLEAR: begin
                foreach (shadow_store[i])
                    shadow_store[i] = '0;
            end
            lrfb_pkg::CMD_LINE: begin
                trace_line(int'(data[7:0]), int'(data[15:8]), int'(data[23:16]),
                           int'(data[31:24]), data[32]);
            end
            lrfb_pkg::CMD_READ: begin
                if (int'(addr) < STORE_DEPTH)
                    value = shadow_store[addr];
            end
            default: begin
                value = '0;
            end
        endcase
        return value;
    endfunction

    always @(posedge aclk) begin : watch_channels
        logic [7:0] want;
        if (!aresetn) begin
            foreach (shadow_store[i])
                shadow_store[i] = '0;
            read_data_queue.delete();
        end else begin
            // retire results before queuing the new command
            if (m_tvalid && m_tready) begin
                if (read_data_queue.size() == 0) begin
                    mismatches++;
                    $display("%0t: unexpected transaction, expected none, got read_data %02h",
                             $time, m_tdata);
                end else begin
                    want = read_data_queue.pop_front();
                    if (m_tdata !== want) begin
                        mismatches++;
                        $display("%0t: read_data mismatch, expected %02h, got %02h",
                                 $time, want, m_tdata);
                    end
                end
            end
            if (s_tvalid && s_tready)
                read_data_queue.push_back(predict_read_data(s_tuser, s_tdata));
        end
        pending    <= read_data_queue.size();
        fail_count <= mismatches;
    end

endmodule

FILE: dv/line_rasterizer_framebuffer_top_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// line_rasterizer_framebuffer_top_test: stimulus for the line rasterizer
// Drives directed corner commands and then random draw, read, clear and
// unused commands in three idling phases, with long result back-pressure and
// full drains in between. The checker module judges every result.
// ----------------------------------------------------------------------------
module line_rasterizer_framebuffer_top_test;

    localparam int SCREEN_WIDTH  = 96;
    localparam int SCREEN_HEIGHT = 68;
    localparam int PAGE_COUNT    = 9;
    localparam int STORE_DEPTH   = SCREEN_WIDTH * PAGE_COUNT;

    localparam logic [1:0] CMD_UNUSED = 2'd3;

    localparam int CYCLE_LIMIT  = 8_000_000;
    localparam int DRAIN_CYCLES = 300;
    localparam int HOLD_CYCLES  = 600;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    // x_start[7:0], y_start[15:8], x_end[23:16], y_end[31:24], ink[32],
    // read_address[42:33], zero fill [47:43]
    logic [47:0] s_tdata  = '0;
    // command[1:0]
    logic [1:0]  s_tuser  = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    // read_data[7:0]
    logic [7:0]  m_tdata;

    int fail_count;
    int pending;
    int cycle_count   = 0;
    int tx_idle_pct   = 0;
    int rx_idle_pct   = 0;
    int hold_requests = 0;
    int holds_done    = 0;
    int hold_left     = 0;
    logic [9:0] probe_addr = '0;

    line_rasterizer_framebuffer_top #(
        .SCREEN_WIDTH (SCREEN_WIDTH),
        .SCREEN_HEIGHT(SCREEN_HEIGHT),
        .PAGE_COUNT   (PAGE_COUNT)
    ) DUT (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .s_tuser (s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata)
    );

    line_rasterizer_framebuffer_checker #(
        .SCREEN_WIDTH (SCREEN_WIDTH),
        .SCREEN_HEIGHT(SCREEN_HEIGHT),
        .PAGE_COUNT   (PAGE_COUNT)
    ) u_checker (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .fail_count(fail_count),
        .pending   (pending)
    );

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // result side: random stalls, or a long hold-off when one is requested
    always @(posedge aclk) begin
        if (hold_left > 0) begin
            m_tready  <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (holds_done != hold_requests) begin
            m_tready   <= 1'b0;
            hold_left  <= HOLD_CYCLES;
            holds_done <= holds_done + 1;
        end else begin
            m_tready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    function automatic logic [47:0] pack_fields(logic [7:0] xs, logic [7:0] ys,
                                                logic [7:0] xe, logic [7:0] ye,
                                                logic ink, logic [9:0] addr);
        return {5'd0, addr, ink, ye, xe, ys, xs};
    endfunction

    function automatic logic [47:0] noise_fields();
        return {5'd0, 11'($urandom), 32'($urandom)};
    endfunction

    // present one command and hold it until the transaction completes
    task automatic drive_command(input logic [1:0] cmd, input logic [47:0] data);
        while ($urandom_range(99) < tx_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= data;
        @(posedge aclk);
        while (!s_tready)
            @(posedge aclk);
    endtask

    task automatic send_line(input logic [7:0] xs, input logic [7:0] ys,
                             input logic [7:0] xe, input logic [7:0] ye, input logic ink);
        drive_command(lrfb_pkg::CMD_LINE, pack_fields(xs, ys, xe, ye, ink, 10'($urandom)));
    endtask

    task automatic send_read(input logic [9:0] addr);
        drive_command(lrfb_pkg::CMD_READ, pack_fields(8'($urandom), 8'($urandom),
                                                      8'($urandom), 8'($urandom),
                                                      1'($urandom), addr));
    endtask

    task automatic wait_results_drained();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending != 0)
            @(posedge aclk);
    endtask

    // remember a pixel of the latest line so later reads land on drawn bytes
    task automatic note_probe(input logic [7:0] col, input logic [7:0] row);
        if (col < SCREEN_WIDTH && row < SCREEN_HEIGHT)
            probe_addr = 10'((row / 8) * SCREEN_WIDTH + col);
    endtask

    task automatic send_random_item();
        int roll;
        int span;
        logic [7:0] xs;
        logic [7:0] ys;
        logic [7:0] xe;
        logic [7:0] ye;
        roll = $urandom_range(99);
        if (roll < 3) begin
            drive_command(lrfb_pkg::CMD_CLEAR, noise_fields());
        end else if (roll < 5) begin
            drive_command(CMD_UNUSED, noise_fields());
        end else if (roll < 40) begin
            span = $urandom_range(9);
            if (span < 5)
                send_read(probe_addr);
            else if (span < 8)
                send_read(10'($urandom_range(STORE_DEPTH - 1)));
            else
                send_read(10'($urandom_range(1023)));
        end else begin
            span = $urandom_range(9);
            if (span < 7) begin
                xs = 8'($urandom_range(SCREEN_WIDTH - 1));
                xe = 8'($urandom_range(SCREEN_WIDTH - 1));
                ys = 8'($urandom_range(SCREEN_HEIGHT - 1));
                ye = 8'($urandom_range(SCREEN_HEIGHT - 1));
            end else if (span < 9) begin
                xs = 8'($urandom_range(127));
                xe = 8'($urandom_range(127));
                ys = 8'($urandom_range(127));
                ye = 8'($urandom_range(127));
            end else begin
                xs = 8'($urandom);
                xe = 8'($urandom);
                ys = 8'($urandom);
                ye = 8'($urandom);
            end
            case ($urandom_range(2))
                0: note_probe(xs, ys);
                1: note_probe(xe, ye);
                default: note_probe(8'((xs + xe) / 2), 8'((ys + ye) / 2));
            endcase
            send_line(xs, ys, xe, ye, $urandom_range(3) != 0);
        end
    endtask

    task automatic run_phase(input int tx_pct, input int rx_pct, input int count,
                             input bit with_hold);
        tx_idle_pct = tx_pct;
        rx_idle_pct <= rx_pct;
        if (with_hold)
            hold_requests <= hold_requests + 1;
        repeat (count)
            send_random_item();
        wait_results_drained();
    endtask

    initial begin
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        // corner commands
        send_read(10'd0);
        send_line(8'd0, 8'd0, 8'd95, 8'd67, 1'b1);
        send_read(10'd0);
        send_line(8'd10, 8'd0, 8'd12, 8'd67, 1'b1);
        send_line(8'd90, 8'd60, 8'd5, 8'd3, 1'b1);
        send_line(8'd50, 8'd30, 8'd50, 8'd30, 1'b1);
        send_read(10'(3 * SCREEN_WIDTH + 50));
        send_line(8'd0, 8'd0, 8'd255, 8'd255, 1'b1);
        send_line(8'd255, 8'd255, 8'd255, 8'd255, 1'b1);
        send_line(8'd0, 8'd255, 8'd255, 8'd0, 1'b1);
        send_line(8'd0, 8'd67, 8'd255, 8'd67, 1'b1);
        send_line(8'd95, 8'd0, 8'd95, 8'd255, 1'b1);
        send_line(8'd40, 8'd60, 8'd45, 8'd2, 1'b1);
        send_read(10'(STORE_DEPTH - 1));
        send_read(10'(8 * SCREEN_WIDTH + 40));
        send_line(8'd0, 8'd0, 8'd95, 8'd67, 1'b0);
        send_read(10'd0);
        send_read(10'(STORE_DEPTH));
        send_read(10'd1023);
        drive_command(CMD_UNUSED, {5'd0, {43{1'b1}}});
        send_read(10'(4 * SCREEN_WIDTH + 95));
        drive_command(lrfb_pkg::CMD_CLEAR, {5'd0, {43{1'b1}}});
        send_read(10'(4 * SCREEN_WIDTH + 95));
        send_read(10'd0);
        wait_results_drained();

        run_phase(28, 76, 650, 1'b1);
        run_phase(76, 28, 650, 1'b0);
        run_phase(0, 0, 600, 1'b1);

        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (fail_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
